// ----- rtl/core/bdq_pkg.sv -----
// shared types and constants for the bounded deque
package bdq_pkg;
    localparam int Capacity = 64;
    localparam int AddrW    = $clog2(Capacity);
    localparam int CountW   = $clog2(Capacity + 1);

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_REMOVE     = 3'd4,
        REQ_CLEAR      = 3'd5,
        REQ_GET        = 3'd6,
        REQ_NONE       = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOOP  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    // one classified transaction passed from front to back
    typedef struct packed {
        t_req         req;
        logic [31:0]  value;
        logic [15:0]  position;
    } t_cmd;
endpackage

// ----- rtl/core/bdq_front.sv -----
// front part: accepts transactions into a two-entry queue
module bdq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [2:0]     i_req_type,
    input  logic [31:0]    i_item_value,
    input  logic [15:0]    i_position,
    output logic           o_cmd_valid,
    output bdq_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_take
);
    import bdq_pkg::*;

    t_cmd        r_q [2];
    logic        r_rd, n_rd;
    logic        r_wr, n_wr;
    logic [1:0]  r_cnt, n_cnt;
    logic        w_push;
    logic        w_pop;

    // queue handshake
    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    // pointer and fill count update
    always_comb begin
        n_rd  = w_pop ? ~r_rd : r_rd;
        n_wr  = w_push ? ~r_wr : r_wr;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{req: t_req'(i_req_type), value: i_item_value,
                           position: i_position};
        end
    end
endmodule

// ----- rtl/core/bdq_back.sv -----
// back part: carries out transactions on the circular store
module bdq_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  bdq_pkg::t_cmd                i_cmd,
    output logic                         o_cmd_take,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [31:0]           o_read_data,
    output logic [bdq_pkg::CountW-1:0]   o_entry_count,
    output logic [1:0]                   o_status
);
    import bdq_pkg::*;

    logic [31:0]        r_mem [Capacity];
    logic [31:0]        r_rdata;
    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [AddrW-1:0]   r_front, n_front;
    logic [CountW-1:0]  r_count, n_count;
    logic [CountW-1:0]  r_idx, n_idx;
    logic [31:0]        r_out_data, n_out_data;
    t_status            r_out_st, n_out_st;
    logic [AddrW-1:0]   w_raddr;
    logic               w_we;
    logic [AddrW-1:0]   w_waddr;
    logic [31:0]        w_wdata;
    logic [CountW-1:0]  w_idx1;

    assign w_idx1        = r_idx + CountW'(1);
    assign o_valid       = (r_state == S_RESULT);
    assign o_read_data   = r_out_data;
    assign o_entry_count = r_count;
    assign o_status      = r_out_st;

    // sequencer: next state, store writes and read address
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_out_data = r_out_data;
        n_out_st   = r_out_st;
        o_cmd_take = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_front + r_idx[AddrW-1:0];
        w_wdata    = r_cmd.value;
        w_raddr    = r_front + r_idx[AddrW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    n_out_data = '0;
                    n_out_st   = ST_DONE;
                    n_idx      = '0;
                    n_state    = S_RESULT;
                    case (i_cmd.req)
                        REQ_PUSH_BACK: begin
                            if (r_count >= CountW'(Capacity)) n_out_st = ST_FULL;
                            else begin
                                w_we    = 1'b1;
                                w_waddr = r_front + r_count[AddrW-1:0];
                                w_wdata = i_cmd.value;
                                n_count = r_count + CountW'(1);
                            end
                        end
                        REQ_PUSH_FRONT: begin
                            if (r_count >= CountW'(Capacity)) n_out_st = ST_FULL;
                            else begin
                                w_we    = 1'b1;
                                w_waddr = r_front - AddrW'(1);
                                w_wdata = i_cmd.value;
                                n_front = r_front - AddrW'(1);
                                n_count = r_count + CountW'(1);
                            end
                        end
                        REQ_POP_BACK: begin
                            if (r_count == '0) n_out_st = ST_NOOP;
                            else n_count = r_count - CountW'(1);
                        end
                        REQ_POP_FRONT: begin
                            if (r_count == '0) n_out_st = ST_NOOP;
                            else begin
                                n_front = r_front + AddrW'(1);
                                n_count = r_count - CountW'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count == '0) n_out_st = ST_NOOP;
                            else begin
                                w_raddr = r_front;
                                n_state = S_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        REQ_GET: begin
                            if ({16'd0, i_cmd.position} >= 32'(r_count))
                                n_out_st = ST_RANGE;
                            else begin
                                w_raddr = r_front + i_cmd.position[AddrW-1:0];
                                n_state = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_out_data = r_rdata;
                n_state    = S_RESULT;
            end
            S_SCAN: begin
                // r_rdata holds entry r_idx
                if (r_rdata == r_cmd.value) begin
                    if (w_idx1 >= r_count) begin
                        n_count = r_count - CountW'(1);
                        n_state = S_RESULT;
                    end else begin
                        w_raddr = r_front + w_idx1[AddrW-1:0];
                        n_state = S_SHIFT;
                    end
                end else if (w_idx1 >= r_count) begin
                    n_out_st = ST_NOOP;
                    n_state  = S_RESULT;
                end else begin
                    w_raddr = r_front + w_idx1[AddrW-1:0];
                    n_idx   = w_idx1;
                end
            end
            S_SHIFT: begin
                // r_rdata holds entry r_idx+1, moved into slot r_idx
                w_we    = 1'b1;
                w_wdata = r_rdata;
                n_idx   = w_idx1;
                if (w_idx1 + CountW'(1) >= r_count) begin
                    n_count = r_count - CountW'(1);
                    n_state = S_RESULT;
                end else begin
                    w_raddr = r_front + AddrW'(r_idx + CountW'(2));
                end
            end
            S_RESULT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
        r_out_st   <= n_out_st;
    end

    // entry store
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end
endmodule

// ----- rtl/core/bounded_deque_with_remove.sv -----
// top level of the bounded deque with remove
//
// A bounded double-ended queue of 64 signed 32-bit entries in a circular
// store. Each input transaction (i_valid, o_stall) carries a request code,
// a value and a position; each gives exactly one result transaction
// (o_valid, i_stall) with the read data, the entry count after the request
// and a status code.
// A two-entry queue at the front takes transactions while the back works.
// Push, pop and clear go from the queue straight to the result register;
// get passes through a read state first. Remove scans the store from the
// front, one entry a cycle over the single store read port, then moves each
// later entry one place forward, one a cycle.
// The back takes a new request only in its idle state, after the previous
// result has been taken.
// The result stays in its register while i_stall is high, and the back
// starts no new request until it is taken; the front queue then fills and
// raises o_stall.
// Synchronous reset empties the deque and the queue; store contents are
// not cleared and are never read before being written.
module bounded_deque_with_remove (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_req_type,
    input  logic signed [31:0]          i_item_value,
    input  logic [15:0]                 i_position,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_read_data,
    output logic [bdq_pkg::CountW-1:0]  o_entry_count,
    output logic [1:0]                  o_status
);
    import bdq_pkg::*;

    t_cmd  w_cmd;
    logic  w_cmd_valid;
    logic  w_cmd_take;

    // front: transaction queue
    bdq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_take   (w_cmd_take)
    );

    // back: store and sequencer
    bdq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_take    (w_cmd_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );
endmodule
